@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL. All checks run on clk_i and are
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

// Condition that must never hold.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed");

`endif

@@ hdl/psev_pkg.sv @@
`default_nettype none
package psev_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CharW = 8;

  localparam logic [CharW-1:0] ChFinish = 8'h3D;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChPlus   = 8'h2B;
  localparam logic [CharW-1:0] ChMinus  = 8'h2D;
  localparam logic [CharW-1:0] ChTimes  = 8'h2A;
  localparam logic [DataW-1:0] ChZero   = 32'd48;

  localparam logic [DataW-1:0] EmptyPopValue = 32'hFFFF_FFF6;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD_UPPER = 2'd1,
    CELL_LOAD_LOWER = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [DataW-1:0]   head;
    logic               push_drop;
    logic               pop_empty;
    logic               finish;
  } stack_upd_t;

endpackage
`default_nettype wire

@@ hdl/psev_cell.sv @@
`default_nettype none
module psev_cell (
  input  wire                         clk_i,
  input  wire psev_pkg::cell_op_e     op_i,
  input  wire [psev_pkg::DataW-1:0]   upper_i,
  input  wire [psev_pkg::DataW-1:0]   lower_i,
  output logic [psev_pkg::DataW-1:0]  value_o
);

  logic [psev_pkg::DataW-1:0] value_q;
  logic [psev_pkg::DataW-1:0] value_d;

  always_comb begin
    case (op_i)
      psev_pkg::CELL_LOAD_UPPER: value_d = upper_i;
      psev_pkg::CELL_LOAD_LOWER: value_d = lower_i;
      default:                   value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
`default_nettype wire

@@ hdl/psev_ctrl.sv @@
`default_nettype none
module psev_ctrl #(
  parameter int unsigned STACK_DEPTH = 16,
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1)
) (
  input  wire [psev_pkg::CharW-1:0]  char_code_i,
  input  wire [CntW-1:0]             count_i,
  input  wire [psev_pkg::DataW-1:0]  top_i,
  input  wire [psev_pkg::DataW-1:0]  lower_i,
  output logic [CntW-1:0]            count_d_o,
  output psev_pkg::stack_upd_t       upd_o
);

  logic [psev_pkg::DataW-1:0] opnd_top;
  logic [psev_pkg::DataW-1:0] opnd_lower;
  logic [psev_pkg::DataW-1:0] digit_val;
  logic                       full;
  logic                       short;

  assign full       = (count_i == CntW'(STACK_DEPTH));
  assign short      = (count_i < CntW'(2));
  // Missing operands read as the empty-pop value.
  assign opnd_top   = (count_i != '0) ? top_i : psev_pkg::EmptyPopValue;
  assign opnd_lower = short ? psev_pkg::EmptyPopValue : lower_i;
  assign digit_val  = {{(psev_pkg::DataW - psev_pkg::CharW){1'b0}}, char_code_i}
                      - psev_pkg::ChZero;

  always_comb begin
    upd_o     = '0;
    upd_o.op  = psev_pkg::CELL_HOLD;
    count_d_o = count_i;
    unique case (char_code_i)
      psev_pkg::ChFinish: begin
        upd_o.finish = 1'b1;
        count_d_o    = '0;
      end
      psev_pkg::ChSpace: begin
        upd_o.op = psev_pkg::CELL_HOLD;
      end
      psev_pkg::ChPlus, psev_pkg::ChMinus, psev_pkg::ChTimes: begin
        // Pop two, push one: the row moves up by one, the result lands on top.
        upd_o.op        = psev_pkg::CELL_LOAD_LOWER;
        upd_o.pop_empty = short;
        count_d_o       = short ? CntW'(1) : count_i - CntW'(1);
        if (char_code_i == psev_pkg::ChPlus) begin
          upd_o.head = opnd_lower + opnd_top;
        end else if (char_code_i == psev_pkg::ChMinus) begin
          upd_o.head = opnd_lower - opnd_top;
        end else begin
          upd_o.head = opnd_lower * opnd_top;
        end
      end
      default: begin
        upd_o.head = digit_val;
        if (full) begin
          upd_o.push_drop = 1'b1;
        end else begin
          upd_o.op  = psev_pkg::CELL_LOAD_UPPER;
          count_d_o = count_i + CntW'(1);
        end
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/postfix_stack_evaluator.sv @@
// Postfix evaluator: one character accepted per cycle, back to back, while the input is not stalled.
// The result of '=' is registered and presented in the cycle after the '=' is accepted.
// The input stalls only while a result is held and the output is stalled.
// The stack is a row of STACK_DEPTH cells shifting one place per cycle when an accepted character pushes or pops.
// Reset clears the stack count, sticky flags and output valid; cells are not reset.
`default_nettype none
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [psev_pkg::CharW-1:0]    char_code_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic signed [psev_pkg::DataW-1:0] top_value_o,
  output logic                         was_empty_o,
  output logic                         overflowed_o,
  output logic                         underflowed_o
);

  `include "assert_macros.svh"

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  logic [STACK_DEPTH-1:0][psev_pkg::DataW-1:0] cell_val;
  logic [CntW-1:0]             count_q, count_d, count_nx;
  logic                        ovf_q, unf_q;
  logic                        out_valid_q;
  logic [psev_pkg::DataW-1:0]  top_q;
  logic                        empty_q, ovf_out_q, unf_out_q;
  logic                        in_acc;
  psev_pkg::stack_upd_t        upd;
  psev_pkg::cell_op_e          row_op;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  psev_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .char_code_i (char_code_i),
    .count_i     (count_q),
    .top_i       (cell_val[0]),
    .lower_i     (cell_val[1]),
    .count_d_o   (count_nx),
    .upd_o       (upd)
  );

  assign row_op = in_acc ? upd.op : psev_pkg::CELL_HOLD;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    psev_pkg::cell_op_e         op;
    logic [psev_pkg::DataW-1:0] upper;
    logic [psev_pkg::DataW-1:0] lower;

    if (i == 0) begin : g_head
      // The top cell always takes the head value when the row moves.
      assign op    = (row_op == psev_pkg::CELL_HOLD) ? psev_pkg::CELL_HOLD
                                                     : psev_pkg::CELL_LOAD_UPPER;
      assign upper = upd.head;
    end else begin : g_body
      assign op    = row_op;
      assign upper = cell_val[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_tail
      assign lower = '0;
    end else begin : g_mid
      assign lower = cell_val[i+1];
    end

    psev_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .upper_i (upper),
      .lower_i (lower),
      .value_o (cell_val[i])
    );
  end

  assign count_d = in_acc ? count_nx : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      unf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        if (upd.finish) begin
          ovf_q <= 1'b0;
          unf_q <= 1'b0;
        end else begin
          ovf_q <= ovf_q | upd.push_drop;
          unf_q <= unf_q | upd.pop_empty;
        end
      end
      if (in_acc && upd.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result on '='.
  always_ff @(posedge clk_i) begin
    if (in_acc && upd.finish) begin
      top_q     <= (count_q != '0) ? cell_val[0] : '0;
      empty_q   <= (count_q == '0);
      ovf_out_q <= ovf_q;
      unf_out_q <= unf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign top_value_o   = top_q;
  assign was_empty_o   = empty_q;
  assign overflowed_o  = ovf_out_q;
  assign underflowed_o = unf_out_q;

  `ASSERT_NEVER(a_count_range, count_q > CntW'(STACK_DEPTH))
  `ASSERT_NEXT(a_finish_clears, in_acc && upd.finish, count_q == '0 && !ovf_q && !unf_q)
  `ASSERT_IMPLY(a_result_source, $rose(out_valid_q), $past(in_acc && upd.finish))
  `ASSERT_IMPLY(a_ovf_on_full, $rose(ovf_q), $past(count_q) == CntW'(STACK_DEPTH))

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic signed [psev_pkg::DataW-1:0] top_value;
    logic                              was_empty;
    logic                              overflowed;
    logic                              underflowed;
  } eval_result_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [psev_pkg::CharW-1:0]        char_code_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [psev_pkg::DataW-1:0] top_value_o;
  logic                              was_empty_o;
  logic                              overflowed_o;
  logic                              underflowed_o;

  postfix_stack_evaluator #(
    .STACK_DEPTH(StackDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .top_value_o  (top_value_o),
    .was_empty_o  (was_empty_o),
    .overflowed_o (overflowed_o),
    .underflowed_o(underflowed_o)
  );

  // Operand stack mirror and the results it predicts
  logic [psev_pkg::DataW-1:0] operand_stack [StackDepth];
  int unsigned                operand_count;
  bit                         push_dropped;
  bit                         pop_was_empty;
  eval_result_t               pending_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned long_hold_cycles;
  int unsigned error_count;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
  end

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [psev_pkg::DataW-1:0] pop_operand();
    if (operand_count == 0) begin
      pop_was_empty = 1'b1;
      return psev_pkg::EmptyPopValue;
    end
    operand_count--;
    return operand_stack[operand_count];
  endfunction

  function automatic void push_operand(logic [psev_pkg::DataW-1:0] value);
    if (operand_count >= StackDepth) begin
      push_dropped = 1'b1;
    end else begin
      operand_stack[operand_count] = value;
      operand_count++;
    end
  endfunction

  function automatic void evaluate_char(logic [psev_pkg::CharW-1:0] code);
    logic [psev_pkg::DataW-1:0] top_operand;
    logic [psev_pkg::DataW-1:0] lower_operand;
    eval_result_t               res;
    if (code == psev_pkg::ChFinish) begin
      res.was_empty   = (operand_count == 0);
      res.top_value   = '0;
      if (operand_count != 0) res.top_value = operand_stack[operand_count-1];
      res.overflowed  = push_dropped;
      res.underflowed = pop_was_empty;
      pending_results.push_back(res);
      operand_count = 0;
      push_dropped  = 1'b0;
      pop_was_empty = 1'b0;
      return;
    end
    case (code)
      psev_pkg::ChSpace: begin
      end
      psev_pkg::ChPlus: begin
        top_operand   = pop_operand();
        lower_operand = pop_operand();
        push_operand(lower_operand + top_operand);
      end
      psev_pkg::ChMinus: begin
        top_operand   = pop_operand();
        lower_operand = pop_operand();
        push_operand(lower_operand - top_operand);
      end
      psev_pkg::ChTimes: begin
        top_operand   = pop_operand();
        lower_operand = pop_operand();
        push_operand(lower_operand * top_operand);
      end
      default: begin
        push_operand(psev_pkg::DataW'(code) - psev_pkg::ChZero);
      end
    endcase
  endfunction

  // Called and returns at a falling edge; leaves valid high for a back-to-back request.
  task automatic send_char(logic [psev_pkg::CharW-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    evaluate_char(code);
    @(negedge clk_i);
  endtask

  task automatic send_string(string text);
    for (int i = 0; i < text.len(); i++) send_char(psev_pkg::CharW'(text[i]));
  endtask

  // Receiver: random stall, with an occasional long hold requested by a test
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (long_hold_cycles) @(negedge clk_i);
        long_hold_cycles = 0;
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    eval_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: top_value %0d", top_value_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (top_value_o !== want.top_value) begin
          $error("top_value: expected %0d, got %0d", want.top_value, top_value_o);
          error_count++;
        end
        if (was_empty_o !== want.was_empty) begin
          $error("was_empty: expected %0b, got %0b", want.was_empty, was_empty_o);
          error_count++;
        end
        if (overflowed_o !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed, overflowed_o);
          error_count++;
        end
        if (underflowed_o !== want.underflowed) begin
          $error("underflowed: expected %0b, got %0b", want.underflowed, underflowed_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_and_underflow();
    // finish on empty stack, then two binary ops that each find too few operands
    send_string("=");
    send_string(" +-=");
  endtask

  task automatic test_operators();
    send_string("75-3*2+=");
  endtask

  task automatic test_overflow();
    // push past the top with the largest and smallest operand codes
    for (int i = 0; i < StackDepth + 1; i++) send_char((i % 2 == 0) ? 8'hFF : 8'h00);
    send_char(psev_pkg::ChFinish);
  endtask

  task automatic test_long_output_hold();
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    long_hold_cycles = 80;
    for (int i = 0; i < 8; i++) begin
      send_char(psev_pkg::CharW'(psev_pkg::ChZero) + psev_pkg::CharW'(i));
      send_char(psev_pkg::ChFinish);
    end
  endtask

  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
                                     int unsigned num_items);
    int unsigned                sent;
    int unsigned                depth;
    int unsigned                push_pct;
    int unsigned                expr_len;
    bit                         noisy;
    logic [psev_pkg::CharW-1:0] code;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < num_items) begin
      noisy    = ($urandom_range(99) < 20);
      push_pct = $urandom_range(75, 35);
      expr_len = $urandom_range(24, 1);
      depth    = 0;
      for (int unsigned k = 0; k < expr_len; k++) begin
        if (noisy) begin
          code = psev_pkg::CharW'($urandom_range(255));
        end else if ($urandom_range(9) == 0) begin
          code = psev_pkg::ChSpace;
        end else if (depth < 2 || $urandom_range(99) < push_pct) begin
          if ($urandom_range(7) == 0) begin
            // odd operand code, anything but an operator, space or finish
            do code = psev_pkg::CharW'($urandom_range(255));
            while (code == psev_pkg::ChFinish || code == psev_pkg::ChSpace ||
                   code == psev_pkg::ChPlus || code == psev_pkg::ChMinus ||
                   code == psev_pkg::ChTimes);
          end else begin
            code = psev_pkg::CharW'(psev_pkg::ChZero) + psev_pkg::CharW'($urandom_range(9));
          end
          depth++;
        end else begin
          case ($urandom_range(2))
            0:       code = psev_pkg::ChPlus;
            1:       code = psev_pkg::ChMinus;
            default: code = psev_pkg::ChTimes;
          endcase
          depth--;
        end
        send_char(code);
        if (code != psev_pkg::ChSpace) sent++;
      end
      send_char(psev_pkg::ChFinish);
      sent++;
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    char_code_i      = '0;
    send_idle_pct    = 13;
    recv_idle_pct    = 45;
    long_hold_cycles = 0;
    error_count      = 0;
    cycle_count      = 0;
    operand_count    = 0;
    push_dropped     = 1'b0;
    pop_was_empty    = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_and_underflow();
    test_operators();
    test_overflow();
    test_long_output_hold();
    test_random_traffic(13, 45, 170);
    test_random_traffic(45, 13, 170);
    test_random_traffic(0, 0, 170);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
